FILE: rtl/core/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned LANES   = 9;
  localparam int unsigned DET_W   = 97;
  localparam int unsigned DMAG_W  = 96;
  localparam int unsigned QBITS   = 32;

  localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [31:0] ZERO_Q16   = 32'h0000_0000;
  localparam logic [31:0] POS_LIMIT  = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;
  localparam logic [30:0] THR_RESET  = 31'd1;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
  } mi3_out_t;

  typedef struct packed {
    logic vld;
    logic sing;
  } div_ctl_t;

endpackage

FILE: rtl/core/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// nine-lane restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module mi3_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mi3_pkg::div_ctl_t   ctl_i,
  input  logic [95:0]         dmag_i,
  input  logic [63:0]         am_i  [9],
  input  logic                neg_i [9],
  output mi3_pkg::div_ctl_t   ctl_o,
  output logic [31:0]         quo_o [9],
  output logic                rnd_o [9],
  output logic                sat_o [9],
  output logic                neg_o [9]
);
  import mi3_pkg::*;

  localparam int unsigned NS = QBITS + 1;

  logic [DMAG_W-1:0] rem_r  [NS][LANES];
  logic [QBITS-1:0]  quo_r  [NS][LANES];
  logic              sat_r  [NS][LANES];
  logic              neg_r  [NS][LANES];
  logic [DMAG_W-1:0] d_r    [NS];
  div_ctl_t          ctl_r  [NS];

  logic [DMAG_W-1:0] rem_nxt [NS][LANES];
  logic              bit_nxt [NS][LANES];
  logic              rnd_end_r [LANES];
  logic [QBITS-1:0]  quo_end_r [LANES];
  logic              sat_end_r [LANES];
  logic              neg_end_r [LANES];
  div_ctl_t          ctl_end_r;

  always_comb begin
    logic [DMAG_W:0] t;
    logic [DMAG_W:0] dd;
    t  = '0;
    dd = '0;
    for (int k = 0; k < LANES; k++) begin
      rem_nxt[0][k] = '0;
      bit_nxt[0][k] = 1'b0;
    end
    for (int s = 1; s < NS; s++) begin
      dd = {1'b0, d_r[s-1]};
      for (int k = 0; k < LANES; k++) begin
        t = {rem_r[s-1][k], 1'b0};
        bit_nxt[s][k] = (t >= dd);
        rem_nxt[s][k] = bit_nxt[s][k] ? DMAG_W'(t - dd) : t[DMAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      rem_r[0][k] <= {32'd0, am_i[k]};
      quo_r[0][k] <= '0;
      sat_r[0][k] <= ({32'd0, am_i[k]} >= dmag_i);
      neg_r[0][k] <= neg_i[k];
    end
    d_r[0] <= dmag_i;
    for (int s = 1; s < NS; s++) begin
      for (int k = 0; k < LANES; k++) begin
        rem_r[s][k] <= rem_nxt[s][k];
        quo_r[s][k] <= {quo_r[s-1][k][QBITS-2:0], bit_nxt[s][k]};
        sat_r[s][k] <= sat_r[s-1][k];
        neg_r[s][k] <= neg_r[s-1][k];
      end
      d_r[s] <= d_r[s-1];
    end
    for (int k = 0; k < LANES; k++) begin
      rnd_end_r[k] <= ({rem_r[NS-1][k], 1'b0} >= {1'b0, d_r[NS-1]});
      quo_end_r[k] <= quo_r[NS-1][k];
      sat_end_r[k] <= sat_r[NS-1][k];
      neg_end_r[k] <= neg_r[NS-1][k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        ctl_r[s] <= '0;
      end
      ctl_end_r <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
      for (int s = 1; s < NS; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      ctl_end_r <= ctl_r[NS-1];
    end
  end

  assign ctl_o = ctl_end_r;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      quo_o[k] = quo_end_r[k];
      rnd_o[k] = rnd_end_r[k];
      sat_o[k] = sat_end_r[k];
      neg_o[k] = neg_end_r[k];
    end
  end

endmodule

FILE: rtl/core/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 matrix inverse by adjugate and determinant, signed q16.16
// ----------------------------------------------------------------------------
// throughput: one matrix per cycle, busy only in the cycle after reset
// depth is set by 6 cofactor/determinant stages, the divider load stage, the
// 32 one-bit divider stages and the rounding and output stages
// reset: synchronous active-low rst_n clears all valid bits and sets the threshold to THR_RESET
// results cannot be stalled by the receiver
module matrix_inverse_3x3 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mi3_pkg::mi3_in_t    in_data,
  output logic                out_valid,
  output mi3_pkg::mi3_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_data
);
  import mi3_pkg::*;

  localparam int unsigned CF_A [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int unsigned CF_B [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int unsigned CF_C [9] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
  localparam int unsigned CF_D [9] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

  logic              busy_r;
  logic [30:0]       thr_r;
  logic              in_acc;
  logic signed [31:0] m [9];

  logic              vld_r [1:5];
  logic signed [63:0] pa_r  [9];
  logic signed [63:0] pb_r  [9];
  logic signed [31:0] row1_r [3];
  logic signed [63:0] adj2_r [9];
  logic signed [31:0] row2_r [3];
  logic signed [63:0] ph3_r  [3];
  logic signed [64:0] pl3_r  [3];
  logic signed [63:0] adj3_r [9];
  logic signed [DET_W-1:0] p4_r [3];
  logic signed [63:0] adj4_r [9];
  logic signed [DET_W-1:0] det5_r;
  logic signed [63:0] adj5_r [9];

  div_ctl_t          ctl6_r;
  logic [DMAG_W-1:0] d6_r;
  logic [63:0]       am6_r  [9];
  logic              neg6_r [9];
  logic              dneg;
  logic [DET_W-1:0]  dabs;
  logic [DMAG_W-1:0] dmag;

  div_ctl_t          dv_ctl;
  logic [31:0]       dv_quo [9];
  logic              dv_rnd [9];
  logic              dv_sat [9];
  logic              dv_neg [9];

  logic [31:0]       res_nxt [9];
  logic [31:0]       res_r   [9];
  logic              out_valid_r;
  logic              sing_r;

  assign in_acc    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  assign m[0] = in_data.a00;
  assign m[1] = in_data.a01;
  assign m[2] = in_data.a02;
  assign m[3] = in_data.a10;
  assign m[4] = in_data.a11;
  assign m[5] = in_data.a12;
  assign m[6] = in_data.a20;
  assign m[7] = in_data.a21;
  assign m[8] = in_data.a22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      thr_r       <= THR_RESET;
      ctl6_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 1; i <= 5; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      vld_r[1] <= in_acc;
      for (int i = 2; i <= 5; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      ctl6_r.vld  <= vld_r[5];
      ctl6_r.sing <= (dmag == '0) || (dmag < {33'd0, thr_r, 32'd0});
      out_valid_r <= dv_ctl.vld;
    end
  end

  always_comb begin
    dneg = det5_r[DET_W-1];
    dabs = dneg ? DET_W'(-det5_r) : DET_W'(det5_r);
    dmag = dabs[DMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      pa_r[k] <= m[CF_A[k]] * m[CF_B[k]];
      pb_r[k] <= m[CF_C[k]] * m[CF_D[k]];
      adj2_r[k] <= pa_r[k] - pb_r[k];
      adj3_r[k] <= adj2_r[k];
      adj4_r[k] <= adj3_r[k];
      adj5_r[k] <= adj4_r[k];
      am6_r[k]  <= adj5_r[k][63] ? 64'(-adj5_r[k]) : 64'(adj5_r[k]);
      neg6_r[k] <= adj5_r[k][63] ^ dneg;
    end
    for (int j = 0; j < 3; j++) begin
      row1_r[j] <= m[j];
      row2_r[j] <= row1_r[j];
      ph3_r[j]  <= $signed(adj2_r[3*j][63:32]) * row2_r[j];
      pl3_r[j]  <= $signed({1'b0, adj2_r[3*j][31:0]}) * row2_r[j];
      p4_r[j]   <= {ph3_r[j][63], ph3_r[j], 32'd0} + {{32{pl3_r[j][64]}}, pl3_r[j]};
    end
    det5_r <= p4_r[0] + p4_r[1] + p4_r[2];
    d6_r   <= dmag;
  end

  mi3_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl6_r),
    .dmag_i (d6_r),
    .am_i   (am6_r),
    .neg_i  (neg6_r),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo),
    .rnd_o  (dv_rnd),
    .sat_o  (dv_sat),
    .neg_o  (dv_neg)
  );

  always_comb begin
    logic [32:0] qq;
    logic [31:0] lim;
    logic [31:0] mag;
    qq  = '0;
    lim = '0;
    mag = '0;
    for (int k = 0; k < 9; k++) begin
      qq  = {1'b0, dv_quo[k]} + {32'd0, dv_rnd[k]};
      lim = dv_neg[k] ? NEG_LIMIT : POS_LIMIT;
      mag = (dv_sat[k] || (qq > {1'b0, lim})) ? lim : qq[31:0];
      if (dv_ctl.sing) begin
        res_nxt[k] = (k % 4 == 0) ? ONE_Q16 : ZERO_Q16;
      end else begin
        res_nxt[k] = dv_neg[k] ? 32'(-mag) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      res_r[k] <= res_nxt[k];
    end
    sing_r <= dv_ctl.sing;
  end

  assign out_valid         = out_valid_r;
  assign out_data.inv00    = res_r[0];
  assign out_data.inv01    = res_r[1];
  assign out_data.inv02    = res_r[2];
  assign out_data.inv10    = res_r[3];
  assign out_data.inv11    = res_r[4];
  assign out_data.inv12    = res_r[5];
  assign out_data.inv20    = res_r[6];
  assign out_data.inv21    = res_r[7];
  assign out_data.inv22    = res_r[8];
  assign out_data.singular = sing_r;

`ifndef SYNTHESIS
  a_sing_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.inv00 == ONE_Q16 && out_data.inv11 == ONE_Q16 &&
      out_data.inv22 == ONE_Q16 && out_data.inv01 == ZERO_Q16)
    else $error("singular result is not the identity");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    ctl6_r.vld && !ctl6_r.sing |-> d6_r != '0)
    else $error("divider fed a zero determinant");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r && !ctl6_r.vld && !dv_ctl.vld)
    else $error("result in flight right after reset");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
// q16.16 matrices are sent through the start/busy port; an internal predictor
// computes the exact adjugate, determinant, singular test and rounded,
// saturated quotients, and every strobed result is compared with the oldest
// expected one. the threshold is rewritten between and within phases, each time while idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mi3_pkg::*;

  localparam int LATENCY = 41;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  mi3_in_t     in_data;
  logic        out_valid;
  mi3_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;

  logic [30:0] thr_model;
  mi3_out_t    inverse_q[$];
  int          errors;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // quotient (adj * 2^32) / |det|, rounded half away from zero, saturated
  function automatic logic [31:0] div_round(logic signed [63:0] adj,
                                            logic [127:0] dmag, logic dneg);
    logic [127:0] am;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] lim;
    logic         neg;
    am  = adj < 0 ? 128'(-adj) : 128'(adj);
    num = am << 32;
    q   = num / dmag;
    r   = num % dmag;
    if ((r << 1) >= dmag) q = q + 1;
    neg = (adj < 0) != dneg;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic mi3_out_t predict_inverse(mi3_in_t a);
    logic signed [63:0]  m[9];
    logic signed [63:0]  adj[9];
    logic signed [127:0] det;
    logic [127:0]        dmag;
    logic                dneg;
    logic [31:0]         v[9];
    mi3_out_t            res;
    m[0] = a.a00; m[1] = a.a01; m[2] = a.a02;
    m[3] = a.a10; m[4] = a.a11; m[5] = a.a12;
    m[6] = a.a20; m[7] = a.a21; m[8] = a.a22;
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[7] * m[2] - m[8] * m[1];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[8] * m[0] - m[6] * m[2];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[6] * m[1] - m[7] * m[0];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = 128'(signed'(adj[0])) * 128'(signed'(m[0]))
        + 128'(signed'(adj[3])) * 128'(signed'(m[1]))
        + 128'(signed'(adj[6])) * 128'(signed'(m[2]));
    dneg = det[127];
    dmag = dneg ? 128'(-det) : 128'(det);
    if (dmag == 0 || dmag < (128'(thr_model) << 32)) begin
      res = '0;
      res.inv00 = ONE_Q16;
      res.inv11 = ONE_Q16;
      res.inv22 = ONE_Q16;
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < 9; i++) v[i] = div_round(adj[i], dmag, dneg);
    res = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 1'b0};
    return res;
  endfunction

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic send_matrix(mi3_in_t a);
    int n;
    start   <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    inverse_q.push_back(predict_inverse(a));
    n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] thr);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = thr;
  endtask

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 512)) - 256) << 16;
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    logic [31:0] e[9];
    int          kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind >= 5) e[i] = rand_elem(1);
      else e[i] = rand_elem($urandom_range(0, 4));
    end
    // dependent rows for near singular cases
    if (kind == 9) begin
      e[6] = e[0] + e[3]; e[7] = e[1] + e[4]; e[8] = e[2] + e[5] + $urandom_range(0, 3);
    end
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic test_directed();
    mi3_in_t a;
    a = '0;
    send_matrix(a);
    a = '0; a.a00 = ONE_Q16; a.a11 = ONE_Q16; a.a22 = ONE_Q16;
    send_matrix(a);
    a.a00 = 32'h0002_0000; a.a11 = 32'hfffc_0000; a.a22 = 32'h0000_8000;
    send_matrix(a);
    a = '0; a.a00 = 32'h7fff_ffff; a.a11 = 32'h7fff_ffff; a.a22 = 32'h7fff_ffff;
    send_matrix(a);
    a = '0; a.a00 = 32'h8000_0000; a.a11 = 32'h8000_0000; a.a22 = 32'h8000_0000;
    send_matrix(a);
    a = '0; a.a00 = 32'd1; a.a11 = 32'd1; a.a22 = 32'd1;
    send_matrix(a);
    a = '0; a.a00 = 32'd3; a.a11 = 32'd3; a.a22 = 32'h0100_0000;
    send_matrix(a);
    a = {9{32'h8000_0000}};
    send_matrix(a);
    a = {9{32'h7fff_ffff}};
    send_matrix(a);
    a = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_matrix(a);
    a = '0; a.a02 = ONE_Q16; a.a10 = ONE_Q16; a.a21 = 32'hffff_0000;
    send_matrix(a);
    a = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
         32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    send_matrix(a);
    a = '0; a.a00 = 32'h0003_0000; a.a11 = 32'h0003_0000; a.a22 = 32'h0003_0000;
    send_matrix(a);
    a = '0; a.a00 = 32'hffff_ffff; a.a11 = 32'h0000_0002; a.a22 = 32'h5555_5555;
    send_matrix(a);
  endtask

  task automatic test_thresholds();
    mi3_in_t a;
    write_threshold(31'd0);
    a = '0; a.a00 = 32'd1; a.a11 = 32'd1; a.a22 = 32'd1;
    send_matrix(a);
    a = '0;
    send_matrix(a);
    write_threshold(31'h7fff_ffff);
    for (int i = 0; i < 8; i++) send_matrix(rand_matrix());
    a = {9{32'h7fff_ffff}};
    a.a01 = 0; a.a02 = 0; a.a10 = 0; a.a12 = 0; a.a20 = 0; a.a21 = 0;
    send_matrix(a);
    write_threshold(31'h0001_0000);
    a = '0; a.a00 = ONE_Q16; a.a11 = ONE_Q16; a.a22 = ONE_Q16;
    send_matrix(a);
    a.a22 = 32'h0000_ffff;
    send_matrix(a);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_matrix(rand_matrix());
      if (i % 350 == 349) begin
        case ($urandom_range(0, 3))
          0: write_threshold(31'd1);
          1: write_threshold(31'($urandom_range(0, 255)));
          2: write_threshold(31'($urandom()));
          default: write_threshold(31'd0);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    mi3_out_t exp_r;
    if (rst_n && out_valid) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        if (exp_r !== out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    errors    = 0;
    thr_model = THR_RESET;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    write_threshold(THR_RESET);
    test_random(1400);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_div.sv
rtl/core/matrix_inverse_3x3.sv
tb/tb_top.sv
